FILE: rtl/core/drs_pkg.sv
`timescale 1ns / 1ps

package drs_pkg;

  // default width of the quadrature position counters
  localparam int unsigned POSITION_WIDTH_DEFAULT = 16;

  // position counters start mid-scale
  localparam logic [31:0] POSITION_RESET = 32'h0000_7FFF;

  // configuration register reset values
  localparam logic [7:0]  WINDOW_LEN_RESET       = 8'd8;
  localparam logic [15:0] REPORT_PERIOD_RESET    = 16'd10;
  localparam logic [15:0] LONG_PRESS_LIMIT_RESET = 16'd100;

  // number of raw pins sampled per tick
  localparam int unsigned NUM_PINS = 6;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WINDOW_LEN       = 2'd0,
    CFG_REPORT_PERIOD    = 2'd1,
    CFG_LONG_PRESS_LIMIT = 2'd2
  } cfg_index_t;

  // reported button state
  typedef enum logic [1:0] {
    BTN_RELEASED = 2'd0,
    BTN_PRESSED  = 2'd1,
    BTN_LONG     = 2'd2
  } button_t;

endpackage

FILE: rtl/core/dual_rotary_encoder_scanner.sv
`timescale 1ns / 1ps

// Dual rotary encoder scanner: takes one word of six raw pin samples (A, B and an
// active-low button for each of two encoders) per clock cycle when the output side
// is free, vote-filters each pin over window_len ticks, tracks a wrapping
// position counter per encoder and, every report_period+1 filtered windows, emits
// one report word with the offset since the previous report, the button state
// (released, pressed, long pressed) and a changed flag per encoder. The whole
// per-tick update sits between the state registers and the output register, so
// the sustained rate is one tick per cycle and a report appears in the cycle after
// the tick that closes its window; the input stalls only while a report sits in
// the output register unclaimed. The first completed window after reset only
// captures reference levels and never produces a report.
module dual_rotary_encoder_scanner #(
  parameter int unsigned POSITION_WIDTH = drs_pkg::POSITION_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // tick samples
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] enc1_a, [1] enc1_b, [2] enc1_btn, [3] enc2_a, [4] enc2_b, [5] enc2_btn
  input  logic [7:0]  s_tdata,
  // reports
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] enc1_offset, [9:8] enc1_button, [10] enc1_changed,
  // [18:11] enc2_offset, [20:19] enc2_button, [21] enc2_changed
  output logic [23:0] m_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [POSITION_WIDTH-1:0] POS_RESET =
    POSITION_WIDTH'(drs_pkg::POSITION_RESET);

  // configuration registers
  logic [7:0]  window_len;
  logic [15:0] report_period;
  logic [15:0] long_press_limit;

  // scanner state
  logic [7:0]                window_ticks;
  logic [7:0]                high_votes [drs_pkg::NUM_PINS];
  logic                      started;
  logic [15:0]               report_ticks;
  logic [1:0]                phase_prev [2];
  logic                      button_prev [2];
  logic [POSITION_WIDTH-1:0] position [2];
  logic [POSITION_WIDTH-1:0] position_reported [2];
  logic [15:0]               hold_count [2];
  logic                      long_seen [2];
  drs_pkg::button_t          button_reported [2];

  // next values
  logic [7:0]                votes_inc [drs_pkg::NUM_PINS];
  logic                      level [drs_pkg::NUM_PINS];
  logic [POSITION_WIDTH-1:0] position_next [2];
  logic [POSITION_WIDTH-1:0] pos_diff [2];
  logic [15:0]               hold_count_next [2];
  logic                      long_seen_next [2];
  drs_pkg::button_t          button_reported_next [2];
  logic [7:0]                offset [2];
  logic                      changed [2];

  logic       in_fire;
  logic       window_open;
  logic [7:0] threshold;
  logic       report_due;
  logic       emit;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;

  // window bookkeeping and threshold vote (more than window_len/2+1 high samples)
  assign window_open = (window_len != 8'd0) && (window_ticks < (window_len - 8'd1));
  assign threshold   = {1'b0, window_len[7:1]} + 8'd1;
  assign report_due  = report_ticks >= report_period;
  assign emit        = in_fire && !window_open && started && report_due;

  always_comb begin
    for (int i = 0; i < drs_pkg::NUM_PINS; i++) begin
      votes_inc[i] = high_votes[i] + {7'd0, s_tdata[i]};
      level[i]     = votes_inc[i] > threshold;
    end
  end

  // per-encoder position step and button report
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      position_next[ch] = position[ch];
      if (level[3*ch] && !phase_prev[ch][0] && (level[3*ch+1] == phase_prev[ch][1])) begin
        if (level[3*ch+1]) begin
          position_next[ch] = position[ch] - POSITION_WIDTH'(1);
        end else begin
          position_next[ch] = position[ch] + POSITION_WIDTH'(1);
        end
      end

      hold_count_next[ch]      = hold_count[ch];
      long_seen_next[ch]       = long_seen[ch];
      button_reported_next[ch] = button_reported[ch];
      priority if (!level[3*ch+2] && button_prev[ch]) begin
        button_reported_next[ch] = drs_pkg::BTN_PRESSED;
      end else if (!level[3*ch+2]) begin
        if (hold_count[ch] < long_press_limit) begin
          hold_count_next[ch] = hold_count[ch] + 16'd1;
        end else if (!long_seen[ch]) begin
          long_seen_next[ch]       = 1'b1;
          button_reported_next[ch] = drs_pkg::BTN_LONG;
        end
      end else begin
        button_reported_next[ch] = drs_pkg::BTN_RELEASED;
        hold_count_next[ch]      = 16'd0;
        long_seen_next[ch]       = 1'b0;
      end

      pos_diff[ch] = position_next[ch] - position_reported[ch];
      offset[ch]   = pos_diff[ch][7:0];
      changed[ch]  = (offset[ch] != 8'd0) || (button_reported_next[ch] != button_reported[ch]);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len       <= drs_pkg::WINDOW_LEN_RESET;
      report_period    <= drs_pkg::REPORT_PERIOD_RESET;
      long_press_limit <= drs_pkg::LONG_PRESS_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (drs_pkg::cfg_index_t'(cfg_index))
        drs_pkg::CFG_WINDOW_LEN:       window_len       <= cfg_data[7:0];
        drs_pkg::CFG_REPORT_PERIOD:    report_period    <= cfg_data;
        drs_pkg::CFG_LONG_PRESS_LIMIT: long_press_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // scanner state update, one tick per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= 8'd0;
      started      <= 1'b0;
      report_ticks <= 16'd0;
      for (int i = 0; i < drs_pkg::NUM_PINS; i++) begin
        high_votes[i] <= 8'd0;
      end
      for (int ch = 0; ch < 2; ch++) begin
        phase_prev[ch]        <= 2'b00;
        button_prev[ch]       <= 1'b1;
        position[ch]          <= POS_RESET;
        position_reported[ch] <= POS_RESET;
        hold_count[ch]        <= 16'd0;
        long_seen[ch]         <= 1'b0;
        button_reported[ch]   <= drs_pkg::BTN_RELEASED;
      end
    end else if (in_fire) begin
      if (window_open) begin
        window_ticks <= window_ticks + 8'd1;
        for (int i = 0; i < drs_pkg::NUM_PINS; i++) begin
          high_votes[i] <= votes_inc[i];
        end
      end else begin
        window_ticks <= 8'd0;
        for (int i = 0; i < drs_pkg::NUM_PINS; i++) begin
          high_votes[i] <= 8'd0;
        end
        for (int ch = 0; ch < 2; ch++) begin
          phase_prev[ch] <= {level[3*ch+1], level[3*ch]};
        end
        if (!started) begin
          // first window only captures reference levels
          started <= 1'b1;
          for (int ch = 0; ch < 2; ch++) begin
            button_prev[ch] <= level[3*ch+2];
          end
        end else begin
          for (int ch = 0; ch < 2; ch++) begin
            position[ch] <= position_next[ch];
          end
          if (report_due) begin
            report_ticks <= 16'd0;
            for (int ch = 0; ch < 2; ch++) begin
              position_reported[ch] <= position_next[ch];
              button_prev[ch]       <= level[3*ch+2];
              hold_count[ch]        <= hold_count_next[ch];
              long_seen[ch]         <= long_seen_next[ch];
              button_reported[ch]   <= button_reported_next[ch];
            end
          end else begin
            report_ticks <= report_ticks + 16'd1;
          end
        end
      end
    end
  end

  // report output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {2'b00, changed[1], button_reported_next[1], offset[1],
                  changed[0], button_reported_next[0], offset[0]};
    end
  end

`ifndef SYNTH
  // no report before the reference window has been captured
  a_no_report_before_start: assert property (@(posedge clk) disable iff (rst)
    !started |-> !m_tvalid)
    else $error("report word present before first window completed");

  // once started, the scanner stays started
  a_started_sticks: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("started flag dropped");

  // a new report always comes from a window that just closed
  a_report_on_window_close: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (window_ticks == 8'd0))
    else $error("report raised without a window close");

  // a recorded long press always shows as long pressed
  a_long_seen_ch0: assert property (@(posedge clk) disable iff (rst)
    long_seen[0] |-> (button_reported[0] == drs_pkg::BTN_LONG))
    else $error("encoder one long press lost");

  a_long_seen_ch1: assert property (@(posedge clk) disable iff (rst)
    long_seen[1] |-> (button_reported[1] == drs_pkg::BTN_LONG))
    else $error("encoder two long press lost");
`endif

endmodule
